/* hw/rtl/ple_pkg.sv */
`default_nettype none

package ple_pkg;

	localparam int DEF_CAPACITY = 64;

	localparam int CMD_W = 3;
	localparam int VAL_W = 32;
	localparam int POS_W = 7;
	localparam int TGT_W = 6;
	localparam int CNT_W = 31;
	localparam int ST_W  = 2;

	localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DUMP    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_MOVE    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd4;
	localparam logic [CMD_W-1:0] CMD_ROT_L   = 3'd5;
	localparam logic [CMD_W-1:0] CMD_ROT_R   = 3'd6;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

/* hw/rtl/ple_mem.sv */
`default_nettype none

module ple_mem
	import ple_pkg::*;
#(
	parameter int DEPTH = DEF_CAPACITY,
	parameter int AW    = $clog2(DEF_CAPACITY)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [VAL_W-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [VAL_W-1:0] rdata_a,
	output logic      [VAL_W-1:0] rdata_b
);

	logic [VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/ple_mod.sv */
`default_nettype none

module ple_mod
	import ple_pkg::*;
#(
	parameter int LW = $clog2(DEF_CAPACITY + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [CNT_W-1:0] dividend,
	input  wire logic [LW-1:0]    divisor,
	output logic                  done,
	output logic      [LW-1:0]    remainder
);

	localparam int BW = $clog2(CNT_W);

	logic             run_q;
	logic             done_q;
	logic [BW-1:0]    bit_q;
	logic [CNT_W-1:0] sh_q;
	logic [LW-1:0]    div_q;
	logic [LW-1:0]    rem_q;
	logic [LW:0]      trial;

	// restoring division, one dividend bit per cycle
	assign trial = {rem_q, sh_q[CNT_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				bit_q <= BW'(CNT_W - 1);
			end else if (run_q) begin
				bit_q <= bit_q - BW'(1);
				if (bit_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			sh_q <= {sh_q[CNT_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_q <= LW'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[LW-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

/* hw/rtl/positional_list_engine.sv */
// Positional list engine: an ordered list of up to CAPACITY signed 32-bit values.
// Input channel (in_valid/in_ready) carries one command per transaction: insert,
// remove, dump, move, reverse, rotate left, rotate right. Output channel
// (out_valid/out_ready) returns one transaction per command with a status, or,
// for dump, one per element (last_result on the final one; an empty list gives
// a single transaction with out_value -1 and list_empty set).
// One command is in work at a time; in_ready is high only when the sequencer is
// idle. A finished result sits in the output register, so the next command is
// taken while it waits. The element store is one memory (one write, two reads,
// registered read data). Steps of each command, with n the list length:
//   insert / remove:  elements behind p shifted one place (one element moved per cycle)
//   move:             take out, then put back
//   reverse:          pairs swapped from both ends inward
//   rotate:           the count reduced modulo n, then three reversals
//   dump:             each element read, then loaded into the output register
// Reset empties the list; no clearing pass is run. When the receiver stalls the
// result holds in the output register and the sequencer waits before the next.
`default_nettype none

module positional_list_engine
	import ple_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic        [CMD_W-1:0] command,
	input  wire logic signed [VAL_W-1:0] item_value,
	input  wire logic        [POS_W-1:0] position,
	input  wire logic        [TGT_W-1:0] target_position,
	input  wire logic        [CNT_W-1:0] shift_count,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed      [VAL_W-1:0] out_value,
	output logic                         list_empty,
	output logic                         last_result,
	output logic             [ST_W-1:0]  status
);

	localparam int LW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SH_RD   = 4'd1;
	localparam logic [3:0] S_SH_WR   = 4'd2;
	localparam logic [3:0] S_PUT     = 4'd3;
	localparam logic [3:0] S_MV_RD   = 4'd4;
	localparam logic [3:0] S_MV_GET  = 4'd5;
	localparam logic [3:0] S_INS     = 4'd6;
	localparam logic [3:0] S_MOD     = 4'd7;
	localparam logic [3:0] S_RV_SET  = 4'd8;
	localparam logic [3:0] S_RV_RD   = 4'd9;
	localparam logic [3:0] S_RV_WA   = 4'd10;
	localparam logic [3:0] S_RV_WB   = 4'd11;
	localparam logic [3:0] S_DP_RD   = 4'd12;
	localparam logic [3:0] S_DP_WAIT = 4'd13;
	localparam logic [3:0] S_FIN     = 4'd14;

	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_WHOLE  = 2'd2;

	logic [3:0]       state_q;
	logic [CMD_W-1:0] cmd_q;
	logic [LW-1:0]    len_q;
	logic [LW-1:0]    idx_q;
	logic [LW-1:0]    bnd_q;
	logic [LW-1:0]    put_pos_q;
	logic             dir_up_q;
	logic [VAL_W-1:0] val_q;
	logic [LW-1:0]    ra_q;
	logic [LW-1:0]    rb_q;
	logic [LW-1:0]    mshift_q;
	logic [1:0]       phase_q;
	logic [ST_W-1:0]  status_q;
	logic [VAL_W-1:0] res_val_q;
	logic             res_empty_q;

	logic             out_valid_q;
	logic [VAL_W-1:0] out_value_q;
	logic             out_empty_q;
	logic             out_last_q;
	logic [ST_W-1:0]  out_status_q;

	logic             accept;
	logic [POS_W-1:0] len7;
	logic [POS_W-1:0] tgt7;
	logic             sh_more;
	logic             rv_more;
	logic [LW-1:0]    rv_a;
	logic [LW-1:0]    rv_b;
	logic [LW-1:0]    rot_m;
	logic             out_free;
	logic             dp_load;
	logic             fin_load;
	logic             dp_last;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [VAL_W-1:0] mem_wdata;
	logic             mem_re;
	logic [LW-1:0]    mem_ra;
	logic [LW-1:0]    mem_rb;
	logic [VAL_W-1:0] rd_a;
	logic [VAL_W-1:0] rd_b;

	logic             mod_start;
	logic             mod_done;
	logic [LW-1:0]    mod_rem;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign len7     = POS_W'(len_q);
	assign tgt7     = POS_W'(target_position);

	assign mod_start = accept && (command inside {CMD_ROT_L, CMD_ROT_R}) && (len_q != '0);

	assign sh_more = dir_up_q ? ((idx_q - LW'(1)) > bnd_q) : ((idx_q + LW'(1)) < bnd_q);
	assign rv_more = (ra_q + LW'(2)) < rb_q;
	assign dp_last = (idx_q + LW'(1)) == len_q;

	always_comb begin
		if (cmd_q == CMD_ROT_L) begin
			rot_m = mod_rem;
		end else if (mod_rem == '0) begin
			rot_m = '0;
		end else begin
			rot_m = len_q - mod_rem;
		end
	end

	// rotate left by m: reverse head part, reverse tail part, reverse whole
	always_comb begin
		case (phase_q)
			PH_FIRST: begin
				rv_a = '0;
				rv_b = mshift_q - LW'(1);
			end
			PH_SECOND: begin
				rv_a = mshift_q;
				rv_b = len_q - LW'(1);
			end
			default: begin
				rv_a = '0;
				rv_b = len_q - LW'(1);
			end
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = rd_a;
		mem_re    = 1'b0;
		mem_ra    = idx_q;
		mem_rb    = rb_q;
		case (state_q)
			S_SH_RD: begin
				mem_re = 1'b1;
				mem_ra = dir_up_q ? (idx_q - LW'(1)) : (idx_q + LW'(1));
			end
			S_SH_WR: begin
				mem_we = 1'b1;
				if (sh_more) begin
					mem_re = 1'b1;
					mem_ra = dir_up_q ? (idx_q - LW'(2)) : (idx_q + LW'(2));
				end
			end
			S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = put_pos_q[AW-1:0];
				mem_wdata = val_q;
			end
			S_MV_RD, S_DP_RD: begin
				mem_re = 1'b1;
			end
			S_RV_RD: begin
				mem_re = 1'b1;
				mem_ra = ra_q;
			end
			S_RV_WA: begin
				mem_we    = 1'b1;
				mem_waddr = ra_q[AW-1:0];
				mem_wdata = rd_b;
			end
			S_RV_WB: begin
				mem_we    = 1'b1;
				mem_waddr = rb_q[AW-1:0];
				if (rv_more) begin
					mem_re = 1'b1;
					mem_ra = ra_q + LW'(1);
					mem_rb = rb_q - LW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	ple_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (mem_re),
		.raddr_a (mem_ra[AW-1:0]),
		.raddr_b (mem_rb[AW-1:0]),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	ple_mod #(
		.LW (LW)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (shift_count),
		.divisor   (len_q),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			phase_q <= PH_FIRST;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q       <= command;
						status_q    <= ST_OK;
						res_val_q   <= '0;
						res_empty_q <= 1'b0;
						state_q     <= S_FIN;
						case (command)
							CMD_INSERT: begin
								if (len_q >= LW'(CAPACITY)) begin
									status_q <= ST_FULL;
								end else if (position > len7) begin
									status_q <= ST_RANGE;
								end else begin
									val_q     <= item_value;
									put_pos_q <= LW'(position);
									if (position == len7) begin
										state_q <= S_PUT;
									end else begin
										idx_q    <= len_q;
										bnd_q    <= LW'(position);
										dir_up_q <= 1'b1;
										state_q  <= S_SH_RD;
									end
								end
							end
							CMD_REMOVE: begin
								if (position >= len7) begin
									status_q <= ST_RANGE;
								end else if ((position + POS_W'(1)) == len7) begin
									len_q <= len_q - LW'(1);
								end else begin
									idx_q    <= LW'(position);
									bnd_q    <= len_q - LW'(1);
									dir_up_q <= 1'b0;
									state_q  <= S_SH_RD;
								end
							end
							CMD_DUMP: begin
								if (len_q == '0) begin
									res_val_q   <= '1;
									res_empty_q <= 1'b1;
								end else begin
									idx_q   <= '0;
									state_q <= S_DP_RD;
								end
							end
							CMD_MOVE: begin
								if ((position >= len7) || (tgt7 >= len7)) begin
									status_q <= ST_RANGE;
								end else begin
									idx_q     <= LW'(position);
									put_pos_q <= LW'(target_position);
									state_q   <= S_MV_RD;
								end
							end
							CMD_REVERSE: begin
								if (len_q >= LW'(2)) begin
									phase_q <= PH_WHOLE;
									state_q <= S_RV_SET;
								end
							end
							CMD_ROT_L, CMD_ROT_R: begin
								if (len_q != '0) begin
									state_q <= S_MOD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SH_RD: begin
					state_q <= S_SH_WR;
				end
				S_SH_WR: begin
					if (sh_more) begin
						idx_q <= dir_up_q ? (idx_q - LW'(1)) : (idx_q + LW'(1));
					end else if (dir_up_q) begin
						state_q <= S_PUT;
					end else begin
						len_q   <= len_q - LW'(1);
						state_q <= (cmd_q == CMD_MOVE) ? S_INS : S_FIN;
					end
				end
				S_PUT: begin
					len_q   <= len_q + LW'(1);
					state_q <= S_FIN;
				end
				S_MV_RD: begin
					state_q <= S_MV_GET;
				end
				S_MV_GET: begin
					val_q <= rd_a;
					if ((idx_q + LW'(1)) == len_q) begin
						len_q   <= len_q - LW'(1);
						state_q <= S_INS;
					end else begin
						bnd_q    <= len_q - LW'(1);
						dir_up_q <= 1'b0;
						state_q  <= S_SH_RD;
					end
				end
				S_INS: begin
					if (put_pos_q == len_q) begin
						state_q <= S_PUT;
					end else begin
						idx_q    <= len_q;
						bnd_q    <= put_pos_q;
						dir_up_q <= 1'b1;
						state_q  <= S_SH_RD;
					end
				end
				S_MOD: begin
					if (mod_done) begin
						if (rot_m == '0) begin
							state_q <= S_FIN;
						end else begin
							mshift_q <= rot_m;
							phase_q  <= PH_FIRST;
							state_q  <= S_RV_SET;
						end
					end
				end
				S_RV_SET: begin
					if (rv_a < rv_b) begin
						ra_q    <= rv_a;
						rb_q    <= rv_b;
						state_q <= S_RV_RD;
					end else if (phase_q == PH_WHOLE) begin
						state_q <= S_FIN;
					end else begin
						phase_q <= phase_q + 2'd1;
					end
				end
				S_RV_RD: begin
					state_q <= S_RV_WA;
				end
				S_RV_WA: begin
					state_q <= S_RV_WB;
				end
				S_RV_WB: begin
					ra_q <= ra_q + LW'(1);
					rb_q <= rb_q - LW'(1);
					if (rv_more) begin
						state_q <= S_RV_WA;
					end else if (phase_q == PH_WHOLE) begin
						state_q <= S_FIN;
					end else begin
						phase_q <= phase_q + 2'd1;
						state_q <= S_RV_SET;
					end
				end
				S_DP_RD: begin
					state_q <= S_DP_WAIT;
				end
				S_DP_WAIT: begin
					if (out_free) begin
						if (dp_last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + LW'(1);
							state_q <= S_DP_RD;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	assign out_free = !out_valid_q || out_ready;
	assign dp_load  = (state_q == S_DP_WAIT) && out_free;
	assign fin_load = (state_q == S_FIN) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_load || fin_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_load) begin
			out_value_q  <= rd_a;
			out_empty_q  <= 1'b0;
			out_last_q   <= dp_last;
			out_status_q <= ST_OK;
		end else if (fin_load) begin
			out_value_q  <= res_val_q;
			out_empty_q  <= res_empty_q;
			out_last_q   <= 1'b1;
			out_status_q <= status_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_value   = out_value_q;
	assign list_empty  = out_empty_q;
	assign last_result = out_last_q;
	assign status      = out_status_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(CAPACITY))
		else $error("list length above capacity");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("store written while idle");

	a_mod_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == S_MOD))
		else $error("modulo result outside rotate wait");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> !$rose(out_last_q) || $past(out_free))
		else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

/* sim/positional_list_engine_test.sv */
module positional_list_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ple_pkg::*;

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic                    empty;
		logic                    last;
		logic [ST_W-1:0]         st;
	} list_result_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [CMD_W-1:0]        command;
	logic signed [VAL_W-1:0] item_value;
	logic [POS_W-1:0]        position;
	logic [TGT_W-1:0]        target_position;
	logic [CNT_W-1:0]        shift_count;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [VAL_W-1:0] out_value;
	logic                    list_empty;
	logic                    last_result;
	logic [ST_W-1:0]         status;

	logic signed [VAL_W-1:0] list_mem [DEF_CAPACITY];
	int                      list_len;
	list_result_t            pending_results [$];
	int                      mismatch_count;
	int                      idle_pct;
	int                      stall_pct;

	positional_list_engine dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.item_value      (item_value),
		.position        (position),
		.target_position (target_position),
		.shift_count     (shift_count),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_value       (out_value),
		.list_empty      (list_empty),
		.last_result     (last_result),
		.status          (status)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("positional_list_engine_test: errors");
		$finish;
	end

	// list model

	function automatic void push_result(logic signed [VAL_W-1:0] v, logic e, logic l,
			logic [ST_W-1:0] s);
		list_result_t r;
		r.value = v;
		r.empty = e;
		r.last  = l;
		r.st    = s;
		pending_results.push_back(r);
	endfunction

	function automatic void list_put(int p, logic signed [VAL_W-1:0] v);
		for (int i = list_len; i > p; i--)
			list_mem[i] = list_mem[i-1];
		list_mem[p] = v;
		list_len++;
	endfunction

	function automatic logic signed [VAL_W-1:0] list_take(int p);
		logic signed [VAL_W-1:0] v;
		v = list_mem[p];
		for (int i = p; i + 1 < list_len; i++)
			list_mem[i] = list_mem[i+1];
		list_len--;
		return v;
	endfunction

	function automatic void list_rotate_left(int unsigned k);
		logic signed [VAL_W-1:0] tmp [DEF_CAPACITY];
		for (int i = 0; i < list_len; i++)
			tmp[i] = list_mem[(i + k) % list_len];
		for (int i = 0; i < list_len; i++)
			list_mem[i] = tmp[i];
	endfunction

	function automatic void apply_command(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] val,
			logic [POS_W-1:0] pos, logic [TGT_W-1:0] tgt, logic [CNT_W-1:0] cnt);
		int              p;
		int              t;
		int unsigned     c;
		int unsigned     k;
		logic signed [VAL_W-1:0] tmp;
		logic [ST_W-1:0] st;
		p  = int'(pos);
		t  = int'(tgt);
		c  = int'(cnt);
		st = ST_OK;
		case (cmd)
			CMD_INSERT: begin
				if (list_len >= DEF_CAPACITY)
					st = ST_FULL;
				else if (p > list_len)
					st = ST_RANGE;
				else
					list_put(p, val);
			end
			CMD_REMOVE: begin
				if (p >= list_len)
					st = ST_RANGE;
				else
					void'(list_take(p));
			end
			CMD_DUMP: begin
				if (list_len == 0) begin
					push_result(-32'sd1, 1'b1, 1'b1, ST_OK);
				end else begin
					for (int i = 0; i < list_len; i++)
						push_result(list_mem[i], 1'b0, i + 1 == list_len, ST_OK);
				end
				return;
			end
			CMD_MOVE: begin
				if (p >= list_len || t > list_len - 1)
					st = ST_RANGE;
				else
					list_put(t, list_take(p));
			end
			CMD_REVERSE: begin
				for (int i = 0; i < list_len / 2; i++) begin
					tmp = list_mem[i];
					list_mem[i] = list_mem[list_len-1-i];
					list_mem[list_len-1-i] = tmp;
				end
			end
			CMD_ROT_L: begin
				if (list_len != 0)
					list_rotate_left(c % list_len);
			end
			CMD_ROT_R: begin
				if (list_len != 0) begin
					k = (list_len - c % list_len) % list_len;
					list_rotate_left(k);
				end
			end
			default: ;
		endcase
		push_result('0, 1'b0, 1'b1, st);
	endfunction

	// transactions

	task automatic send_cmd(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] val,
			int pos, int tgt, logic [CNT_W-1:0] cnt);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		command         <= cmd;
		item_value      <= val;
		position        <= pos[POS_W-1:0];
		target_position <= tgt[TGT_W-1:0];
		shift_count     <= cnt;
		do
			@(posedge clk);
		while (!in_ready);
		apply_command(cmd, val, pos[POS_W-1:0], tgt[TGT_W-1:0], cnt);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	function automatic void check_field(string name, longint expv, longint actv);
		if (expv != actv) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		list_result_t exp_r;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual value %0d status %0d",
					$time, out_value, status);
				mismatch_count++;
			end else begin
				exp_r = pending_results.pop_front();
				check_field("out_value", exp_r.value, out_value);
				check_field("list_empty", exp_r.empty, list_empty);
				check_field("last_result", exp_r.last, last_result);
				check_field("status", exp_r.st, status);
			end
		end
	end

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(19))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [CNT_W-1:0] pick_count();
		if ($urandom_range(1))
			return CNT_W'($urandom_range(200));
		return CNT_W'($urandom >> 1);
	endfunction

	// tests

	task automatic test_empty_list();
		send_cmd(CMD_DUMP, '0, 0, 0, '0);
		send_cmd(CMD_REMOVE, '0, 0, 0, '0);
		send_cmd(CMD_MOVE, '0, 0, 0, '0);
		send_cmd(CMD_REVERSE, '0, 0, 0, '0);
		send_cmd(CMD_ROT_L, '0, 0, 0, 31'd5);
		send_cmd(CMD_ROT_R, '0, 0, 0, 31'h7fff_ffff);
		send_cmd(CMD_INSERT, 32'sd7, 1, 0, '0);
		send_cmd(CMD_INSERT, 32'sd7, 64, 0, '0);
	endtask

	task automatic test_boundaries();
		send_cmd(CMD_INSERT, 32'sh8000_0000, 0, 0, '0);
		send_cmd(CMD_INSERT, 32'sh7fff_ffff, 1, 0, '0);
		send_cmd(CMD_INSERT, -32'sd1, 0, 0, '0);
		send_cmd(CMD_INSERT, '0, 1, 0, '0);
		send_cmd(CMD_DUMP, '0, 0, 0, '0);
		send_cmd(CMD_MOVE, '0, 3, 0, '0);
		send_cmd(CMD_MOVE, '0, 0, 3, '0);
		send_cmd(CMD_MOVE, '0, 1, 4, '0);
		send_cmd(CMD_MOVE, '0, 4, 0, '0);
		send_cmd(CMD_REVERSE, '0, 0, 0, '0);
		send_cmd(CMD_ROT_L, '0, 0, 0, 31'h7fff_ffff);
		send_cmd(CMD_ROT_R, '0, 0, 0, 31'd1);
		send_cmd(CMD_REMOVE, '0, 4, 0, '0);
		send_cmd(CMD_REMOVE, '0, 3, 0, '0);
		send_cmd(CMD_REMOVE, '0, 0, 0, '0);
		send_cmd(CMD_REVERSE, '0, 0, 0, '0);
		send_cmd(CMD_REMOVE, '0, 0, 0, '0);
		send_cmd(CMD_REVERSE, '0, 0, 0, '0);
		send_cmd(CMD_REMOVE, '0, 0, 0, '0);
	endtask

	task automatic test_capacity();
		while (list_len < DEF_CAPACITY)
			send_cmd(CMD_INSERT, pick_value(), $urandom_range(list_len), 0, '0);
		send_cmd(CMD_INSERT, pick_value(), 64, 0, '0);
		send_cmd(CMD_INSERT, pick_value(), 0, 0, '0);
		send_cmd(CMD_DUMP, '0, 0, 0, '0);
		send_cmd(CMD_REMOVE, '0, 64, 0, '0);
		send_cmd(CMD_MOVE, '0, 63, 63, '0);
		send_cmd(CMD_MOVE, '0, 0, 63, '0);
		send_cmd(CMD_ROT_L, '0, 0, 0, pick_count());
		send_cmd(CMD_ROT_R, '0, 0, 0, pick_count());
		send_cmd(CMD_REVERSE, '0, 0, 0, '0);
		send_cmd(CMD_REMOVE, '0, 63, 0, '0);
		send_cmd(CMD_INSERT, pick_value(), 63, 0, '0);
		send_cmd(CMD_DUMP, '0, 0, 0, '0);
	endtask

	task automatic test_random_mix(int n, int insert_pct);
		int sel;
		int pos;
		int tgt;
		for (int i = 0; i < n; i++) begin
			pos = $urandom_range(64);
			tgt = $urandom_range(63);
			if ($urandom_range(99) < insert_pct) begin
				if ($urandom_range(9) != 0)
					pos = $urandom_range(list_len > 64 ? 64 : list_len);
				send_cmd(CMD_INSERT, pick_value(), pos, 0, '0);
			end else begin
				if (list_len > 0 && $urandom_range(9) != 0) begin
					pos = $urandom_range(list_len - 1);
					tgt = $urandom_range(list_len - 1);
				end
				sel = $urandom_range(99);
				if (sel < 40)
					send_cmd(CMD_REMOVE, pick_value(), pos, tgt, pick_count());
				else if (sel < 50)
					send_cmd(CMD_DUMP, pick_value(), pos, tgt, pick_count());
				else if (sel < 70)
					send_cmd(CMD_MOVE, pick_value(), pos, tgt, pick_count());
				else if (sel < 80)
					send_cmd(CMD_REVERSE, pick_value(), pos, tgt, pick_count());
				else if (sel < 90)
					send_cmd(CMD_ROT_L, pick_value(), pos, tgt, pick_count());
				else
					send_cmd(CMD_ROT_R, pick_value(), pos, tgt, pick_count());
			end
		end
	endtask

	initial begin
		mismatch_count  = 0;
		list_len        = 0;
		idle_pct        = 0;
		stall_pct       = 0;
		arst_n          <= 1'b0;
		in_valid        <= 1'b0;
		out_ready       <= 1'b0;
		command         <= CMD_INSERT;
		item_value      <= '0;
		position        <= '0;
		target_position <= '0;
		shift_count     <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_boundaries();
		wait_for_results();

		idle_pct  = 52;
		stall_pct = 0;
		test_capacity();

		idle_pct  = 0;
		stall_pct = 52;
		test_random_mix(70, 45);

		idle_pct  = 12;
		stall_pct = 12;
		test_random_mix(70, 25);

		idle_pct  = 0;
		stall_pct = 0;
		test_random_mix(27, 55);

		wait_for_results();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("positional_list_engine_test: clean");
		else
			$display("positional_list_engine_test: errors");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/ple_pkg.sv
hw/rtl/ple_mem.sv
hw/rtl/ple_mod.sv
hw/rtl/positional_list_engine.sv
sim/positional_list_engine_test.sv
